### src/rptc_pkg.sv
// ----------------------------------------------------------------------------
// rptc_pkg: shared types and constants of the memory pattern test block
// Holds the request and result payloads, the controller to datapath command
// and status groups, and the pattern and hash constants.
// ----------------------------------------------------------------------------
package rptc_pkg;

    // test memory geometry
    localparam int DEPTH_WORDS = 65536;
    localparam int ADDR_W      = (DEPTH_WORDS > 1) ? $clog2(DEPTH_WORDS) : 1;
    localparam int CNT_W       = $clog2(DEPTH_WORDS + 1);
    localparam int WORD_W      = 32;
    localparam int WCOUNT_W    = 17;

    // pattern steps and fnv-1a constants
    localparam logic [WORD_W-1:0] STEP_ONE  = 32'd2654435761;
    localparam logic [WORD_W-1:0] STEP_TWO  = 32'd40503;
    localparam logic [WORD_W-1:0] FNV_BASIS = 32'h811c9dc5;
    localparam logic [WORD_W-1:0] FNV_PRIME = 32'h01000193;

    // request payload
    typedef struct packed {
        logic [WORD_W-1:0]   seed;
        logic [WCOUNT_W-1:0] word_count;
    } req_t;

    // result payload
    typedef struct packed {
        logic              fail;
        logic [WORD_W-1:0] checksum;
    } res_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;        // capture request, start round one write
        logic write;       // write pattern word, advance
        logic read_cmp;    // read word for compare, advance
        logic read_hash;   // read word for hashing, advance
        logic rewind;      // back to address zero at the base of next_round
        logic next_round;  // round selected by rewind
        logic publish;     // load the result register
    } ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic at_end;      // address counter has reached the word count
        logic mismatch;    // a read-back word differed
        logic round;       // current round, 0 or 1
        logic res_free;    // result register can take a new result
    } sts_t;

endpackage

### src/rptc_datapath.sv
// ----------------------------------------------------------------------------
// rptc_datapath: test memory, pattern generator, compare and hash
// Runs one memory access per cycle as commanded by the controller, checks
// or hashes read data in the cycle after its read and holds the result register.
// ----------------------------------------------------------------------------
module rptc_datapath
    import rptc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req_data,
    input  ctl_t ctl,
    output sts_t sts,
    output logic res_valid,
    input  logic res_stall,
    output res_t res_data
);

    logic [WORD_W-1:0] mem [DEPTH_WORDS];

    logic [WORD_W-1:0] seed_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  addr_reg;
    logic [WORD_W-1:0] pattern_reg;
    logic              round_reg;
    logic [WORD_W-1:0] rd_data_reg;
    logic [WORD_W-1:0] exp_reg;
    logic              rd_pend_reg;
    logic              rd_hash_reg;
    logic              mismatch_reg;
    logic [WORD_W-1:0] hash_reg;
    logic              res_valid_reg;
    res_t              res_reg;

    logic [WORD_W-1:0] step;
    logic [WORD_W-1:0] rewind_base;
    logic [WORD_W-1:0] hash_mix;
    logic [WORD_W-1:0] hash_prod;
    logic              access;

    // word count saturated to the memory depth
    always_comb
    begin
        if (32'(req_data.word_count) > 32'(DEPTH_WORDS))
            count_next = CNT_W'(DEPTH_WORDS);
        else
            count_next = CNT_W'(req_data.word_count);
    end

    // round constants and hash step
    always_comb
    begin
        step        = round_reg ? STEP_TWO : STEP_ONE;
        rewind_base = ctl.next_round ? ~seed_reg : seed_reg;
        hash_mix    = hash_reg ^ rd_data_reg;
        hash_prod   = hash_mix * FNV_PRIME;
        access      = ctl.write | ctl.read_cmp | ctl.read_hash;
    end

    // single port test memory with registered read
    always_ff @(posedge clk)
    begin
        if (ctl.write)
            mem[addr_reg[ADDR_W-1:0]] <= pattern_reg;
        if (ctl.read_cmp | ctl.read_hash)
            rd_data_reg <= mem[addr_reg[ADDR_W-1:0]];
    end

    // request capture, address counter and pattern generator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg  <= '0;
            count_reg <= '0;
            round_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            addr_reg  <= '0;
            count_reg <= count_next;
            round_reg <= 1'b0;
        end
        else if (ctl.rewind)
        begin
            addr_reg  <= '0;
            round_reg <= ctl.next_round;
        end
        else if (access)
        begin
            addr_reg <= addr_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            seed_reg    <= req_data.seed;
            pattern_reg <= req_data.seed;
        end
        else if (ctl.rewind)
            pattern_reg <= rewind_base;
        else if (access)
            pattern_reg <= pattern_reg + step;
        if (ctl.read_cmp | ctl.read_hash)
            exp_reg <= pattern_reg;
    end

    // read tracking, compare and fnv-1a hash
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg  <= 1'b0;
            rd_hash_reg  <= 1'b0;
            mismatch_reg <= 1'b0;
            hash_reg     <= FNV_BASIS;
        end
        else
        begin
            rd_pend_reg <= ctl.read_cmp | ctl.read_hash;
            rd_hash_reg <= ctl.read_hash;
            if (ctl.load)
            begin
                mismatch_reg <= 1'b0;
                hash_reg     <= FNV_BASIS;
            end
            else if (rd_pend_reg)
            begin
                if (rd_hash_reg)
                    hash_reg <= hash_prod;
                else if (rd_data_reg != exp_reg)
                    mismatch_reg <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (ctl.publish)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.publish)
        begin
            res_reg.fail     <= mismatch_reg;
            res_reg.checksum <= mismatch_reg ? '0 : hash_reg;
        end
    end

    // status back to the controller
    always_comb
    begin
        sts.at_end   = (addr_reg == count_reg);
        sts.mismatch = mismatch_reg;
        sts.round    = round_reg;
        sts.res_free = !res_valid_reg || !res_stall;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

### src/rptc_ctrl.sv
// ----------------------------------------------------------------------------
// rptc_ctrl: sequencer of the memory pattern test
// Steps through write, read-compare and hash passes and issues at most one
// datapath command per cycle.
// ----------------------------------------------------------------------------
module rptc_ctrl
    import rptc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  sts_t sts,
    output ctl_t ctl
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WR   = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_CHK  = 3'd3;
    localparam logic [2:0] ST_HASH = 3'd4;
    localparam logic [2:0] ST_HEND = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0] state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_WR;
                end
            end
            ST_WR:
            begin
                if (sts.at_end)
                begin
                    ctl.rewind     = 1'b1;
                    ctl.next_round = sts.round;
                    state_next     = ST_RD;
                end
                else
                    ctl.write = 1'b1;
            end
            ST_RD:
            begin
                if (sts.at_end)
                    state_next = ST_CHK;
                else
                    ctl.read_cmp = 1'b1;
            end
            ST_CHK:
            begin
                // last compare has landed
                if (sts.mismatch)
                    state_next = ST_DONE;
                else if (!sts.round)
                begin
                    ctl.rewind     = 1'b1;
                    ctl.next_round = 1'b1;
                    state_next     = ST_WR;
                end
                else
                begin
                    ctl.rewind     = 1'b1;
                    ctl.next_round = 1'b1;
                    state_next     = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (sts.at_end)
                    state_next = ST_HEND;
                else
                    ctl.read_hash = 1'b1;
            end
            ST_HEND:
            begin
                // last hash step lands here
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.res_free)
                begin
                    ctl.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign req_stall = (state_reg != ST_IDLE);

endmodule

### src/ram_pattern_test_checksum.sv
// ----------------------------------------------------------------------------
// ram_pattern_test_checksum: memory pattern self-test with fnv-1a checksum
// Each request writes and verifies two address-linear patterns over the
// first word_count words of an internal 32-bit test memory (word_count is
// saturated to the depth), then returns a word-wise fnv-1a hash of the final
// contents, or fail with a zero checksum on the first mismatching round.
// One request is in work at a time. A passing request makes five passes
// over the single-port test memory, which performs one word access per
// cycle, with a turnaround step after each pass and the check, hash and
// publish steps. A failing request ends after its failing round. A result
// waits in its own register, and the next request is taken while it is
// held.
// ----------------------------------------------------------------------------
module ram_pattern_test_checksum
    import rptc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic res_valid,
    input  logic res_stall,
    output res_t res_data
);

    ctl_t ctl;
    sts_t sts;

    // sequencer
    rptc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    // memory, pattern, compare and hash
    rptc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .ctl       (ctl),
        .sts       (sts),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

### src/rptc_checker.sv
// ----------------------------------------------------------------------------
// rptc_checker: port-level checks of the memory pattern test block
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module rptc_checker
    import rptc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input logic res_valid,
    input logic res_stall,
    input res_t res_data
);

    // a held result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // a failing test reports a zero checksum
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!res_data.fail || (res_data.checksum == '0)))
        else $error("fail result with non-zero checksum");

    // one request in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while busy");

    // no result right on the heels of a request
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> !$rose(res_valid))
        else $error("result appeared one cycle after request");

endmodule

bind ram_pattern_test_checksum rptc_checker u_checker (.*);

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the memory pattern self-test block
// Requests queued by the stimulus block are driven on the request channel
// with random gaps, and the result channel is stalled at random. Each
// accepted request is run through a behavioural copy of the test (two
// pattern rounds over a local memory array, then an fnv-1a hash), and every
// result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import rptc_pkg::*;

    // a full-depth request runs through five memory passes with no handshake
    localparam int WATCHDOG_LIMIT = 1400000;
    localparam int DRAIN_CYCLES   = 400;
    localparam int RANDOM_REQS    = 100;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data  = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res_data;

    // stimulus and scoreboard storage
    req_t pending_reqs[$];
    res_t expected_results[$];
    bit [WORD_W-1:0] test_words [DEPTH_WORDS];

    int req_issued   = 0;
    int req_accepts  = 0;
    int req_gap      = 0;
    int res_accepts  = 0;
    int res_seen     = 0;
    int res_wait     = 0;
    int idle_cycles  = 0;
    int fail_count   = 0;

    ram_pattern_test_checksum u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always #5 clk = ~clk;

    // idle cycles before the next transfer, biased towards back-to-back runs
    function automatic int draw_wait();
        if ($urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 7);
    endfunction

    // two write/verify rounds over the local memory, then hash the contents
    function automatic res_t predict_self_test(req_t req);
        bit [WORD_W-1:0] n;
        bit [WORD_W-1:0] idx;
        bit [WORD_W-1:0] base;
        bit [WORD_W-1:0] step;
        bit [WORD_W-1:0] hash;
        bit              mismatch;
        res_t            res;
        n        = (req.word_count > DEPTH_WORDS) ? DEPTH_WORDS : req.word_count;
        mismatch = 1'b0;
        for (int pass_idx = 0; pass_idx < 2 && !mismatch; pass_idx++)
        begin
            base = (pass_idx == 0) ? req.seed : ~req.seed;
            step = (pass_idx == 0) ? STEP_ONE : STEP_TWO;
            for (idx = 0; idx < n; idx++)
                test_words[idx[ADDR_W-1:0]] = base + idx * step;
            for (idx = 0; idx < n; idx++)
                if (test_words[idx[ADDR_W-1:0]] != base + idx * step)
                    mismatch = 1'b1;
        end
        hash = FNV_BASIS;
        for (idx = 0; idx < n; idx++)
            hash = (hash ^ test_words[idx[ADDR_W-1:0]]) * FNV_PRIME;
        res.fail     = mismatch;
        res.checksum = mismatch ? '0 : hash;
        return res;
    endfunction

    task automatic add_request(input bit [WORD_W-1:0] seed,
                               input bit [WCOUNT_W-1:0] count);
        req_t req;
        req.seed       = seed;
        req.word_count = count;
        pending_reqs.push_back(req);
    endtask

    // request driver: holds a stalled request, otherwise gap or next request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!(req_valid && req_accepts != req_issued))
            begin
                if (req_gap > 0)
                begin
                    req_valid <= 1'b0;
                    req_gap = req_gap - 1;
                end
                else if (pending_reqs.size() > 0)
                begin
                    req_data  <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                    req_issued = req_issued + 1;
                    req_gap    = draw_wait();
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // result stall: a fresh random hold-off after every accepted result
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_accepts != res_seen)
            begin
                res_seen = res_accepts;
                res_wait = draw_wait();
            end
            if (res_wait > 0)
            begin
                res_stall <= 1'b1;
                res_wait = res_wait - 1;
            end
            else
            begin
                res_stall <= 1'b0;
            end
        end
    end

    // monitor: check results, record predictions, count idle cycles
    always @(posedge clk)
    begin : monitor
        res_t want;
        bit   moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                moved = 1'b1;
                res_accepts = res_accepts + 1;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result fail=%0b checksum=%h",
                             $time, res_data.fail, res_data.checksum);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res_data.fail !== want.fail)
                    begin
                        $display("%0t: fail mismatch expected %0b actual %0b",
                                 $time, want.fail, res_data.fail);
                        fail_count = fail_count + 1;
                    end
                    if (res_data.checksum !== want.checksum)
                    begin
                        $display("%0t: checksum mismatch expected %h actual %h",
                                 $time, want.checksum, res_data.checksum);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                moved = 1'b1;
                req_accepts = req_accepts + 1;
                expected_results.push_back(predict_self_test(req_data));
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        bit timed_out;
        int pick;
        bit [WCOUNT_W-1:0] count;

        // directed: empty, tiny and full-depth tests, seed extremes
        add_request(32'h0000_0000, 17'd0);
        add_request(32'hffff_ffff, 17'd0);
        add_request(32'h0000_0000, 17'd1);
        add_request(32'hffff_ffff, 17'd1);
        add_request(32'h8000_0000, 17'd2);
        add_request(32'h0000_0001, 17'd3);
        add_request(32'h7fff_ffff, 17'd5);
        add_request(32'h5555_5555, 17'd16);
        add_request(32'haaaa_aaaa, 17'd17);
        // count above depth saturates to a full-depth test
        add_request($urandom, 17'h1ffff);
        add_request($urandom, 17'd0);
        add_request($urandom, 17'd64);

        // random: mostly short tests, some medium, a few longer
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                count = WCOUNT_W'($urandom_range(0, 32));
            else if (pick < 95)
                count = WCOUNT_W'($urandom_range(33, 1024));
            else
                count = WCOUNT_W'($urandom_range(1025, 4096));
            add_request($urandom, count);
        end

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // wait for every request to be taken and every result checked
        timed_out = 1'b0;
        while (!timed_out && !(pending_reqs.size() == 0 &&
               req_accepts == req_issued && expected_results.size() == 0))
        begin
            @(negedge clk);
            if (idle_cycles >= WATCHDOG_LIMIT)
                timed_out = 1'b1;
        end
        if (!timed_out)
            repeat (DRAIN_CYCLES) @(negedge clk);

        if (timed_out)
            $display("simulation failed");
        else if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### ram_pattern_test_checksum.f
src/rptc_pkg.sv
src/rptc_datapath.sv
src/rptc_ctrl.sv
src/ram_pattern_test_checksum.sv
src/rptc_checker.sv
verif/testbench.sv
